// ----- src/dspt_pkg.sv -----
// Package with shared types and constants for the distance spaced position trail.
package dspt_pkg;

	// Default configuration of the trail.
	localparam int DEF_TRAIL_DEPTH  = 64;
	localparam int DEF_TILE         = 16;
	localparam int DEF_MAX_SIDE_GAP = 15;

	// Rail connection code that means no connection.
	localparam logic [15:0] NO_LINK = 16'hFFFF;

	// The x weight is sixteen, a shift by four; the z weight is sixteen plus the gap.
	localparam int          X_WEIGHT_SHIFT = 4;
	localparam logic [4:0]  Z_WEIGHT_BASE  = 5'd16;

	// Movement kind code for rail movement.
	localparam logic KIND_RAIL = 1'b0;

	// Command codes.
	localparam logic CMD_PUSH  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// Result status codes.
	localparam logic [1:0] STAT_NONE  = 2'd0;
	localparam logic [1:0] STAT_EMIT  = 2'd1;
	localparam logic [1:0] STAT_RESET = 2'd2;

	// One stored sample.
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [15:0] space;
		logic        kind;
		logic [1:0]  facing;
		logic [15:0] rail;
		logic [15:0] link;
		logic [31:0] epoch;
	} rec_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DELTA,
		S_MUL1,
		S_MUL2,
		S_SUM,
		S_ROOT,
		S_GOTA,
		S_GOTB
	} state_t;

	// What the current square root is computed for.
	typedef enum logic [1:0] {
		PH_PLANAR,
		PH_WEIGHT,
		PH_TRIM
	} phase_t;

endpackage

// ----- src/distance_spaced_position_trail_core.sv -----
// Top level of the distance spaced position trail: ring memory, root unit and sequencer.
//
// A request is taken when start is high and busy is low; its single result appears
// on the result ports for one cycle with done high, and cannot be held off. A clear
// request, an invalid sample or a push into an empty ring shows its result in the
// cycle after it is taken. Any other push reads the newest sample, then runs the
// shared bit-serial square root unit, which yields RW/2 root bits (12 with the
// default tile of 16). A push costs one planar root, one weighted root when it is
// stored, and one more weighted root plus one memory read for each trim check; the
// first trim check also reads the oldest sample. The ring lives in one memory with
// one read and one write port and a registered read; no clearing pass is needed
// since only written entries are ever read.
module distance_spaced_position_trail_core
	import dspt_pkg::*;
#(
	parameter int TRAIL_DEPTH  = DEF_TRAIL_DEPTH,
	parameter int TILE         = DEF_TILE,
	parameter int MAX_SIDE_GAP = DEF_MAX_SIDE_GAP
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cmd,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [15:0]        space_id,
	input  logic [1:0]         move_kind,
	input  logic [2:0]         facing,
	input  logic [31:0]        epoch,
	input  logic [15:0]        rail_id,
	input  logic [15:0]        link_id,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_data,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [15:0]        out_space,
	output logic               out_kind,
	output logic [1:0]         out_facing,
	output logic [31:0]        out_epoch,
	output logic [15:0]        out_rail,
	output logic [15:0]        out_link
);

	localparam int AW  = (TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1;
	localparam int CW  = $clog2(TRAIL_DEPTH + 1);
	localparam int DW  = $clog2(3 * TILE + 1);
	localparam int WXW = DW + 5;
	localparam int SW  = 2 * WXW + 1;
	localparam int RW  = SW + (SW % 2);
	localparam int RTW = RW / 2;

	localparam logic [32:0]   LIM2     = 33'(2 * TILE);
	localparam logic [DW-1:0] CLAMP    = DW'(3 * TILE);
	localparam logic [DW-1:0] Y_LIMIT  = DW'(2 * TILE);
	localparam logic [CW-1:0] DEPTH_C  = CW'(TRAIL_DEPTH);
	localparam logic [31:0]   TILE_C   = 32'(TILE);
	localparam logic [7:0]    MAXGAP_C = 8'(MAX_SIDE_GAP);

	// Clamped absolute difference of one axis.
	function automatic logic [DW-1:0] adelta(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] d;
		logic [32:0] m;
		d = {a[31], a} - {b[31], b};
		m = d[32] ? (33'd0 - d) : d;
		if (m > LIM2) begin
			return CLAMP;
		end
		return m[DW-1:0];
	endfunction

	// Ring index wrap for a sum below twice the depth.
	function automatic logic [AW-1:0] wrap(input logic [CW:0] s);
		logic [CW:0] r;
		r = (s >= (CW + 1)'(TRAIL_DEPTH)) ? (s - (CW + 1)'(TRAIL_DEPTH)) : s;
		return r[AW-1:0];
	endfunction

	state_t state_q, nx_state;
	phase_t phase_q, nx_phase;

	logic [3:0]     side_gap_q;
	logic [AW-1:0]  head_q;
	logic [CW-1:0]  count_q;
	logic [31:0]    path_q;
	rec_t           in_q, last_q, a_q, b_q, rdata_q;
	logic [DW-1:0]  dx_q, dz_q;
	logic           dy_big_q;
	logic [WXW-1:0] wx_q, wz_q;
	logic [2*WXW-1:0] sqx_q, sqz_q;
	logic [RW-1:0]  rem_q, res_q, bit_q;
	logic           done_q;
	rec_t           out_q;
	logic [1:0]     status_q;

	rec_t mem [TRAIL_DEPTH];

	// Combinational control.
	logic          mem_we, mem_re, fin;
	logic [AW-1:0] waddr, raddr;
	rec_t          wdata, fin_rec, in_rec, op_a;
	logic [1:0]    fin_stat;
	logic          do_clear, do_first, do_app, do_add, do_trim, ld_a, ld_b, ld_d;
	logic          bad_in;
	logic [4:0]    gain;
	logic [31:0]   thr, root32, path_add, path_sub;
	logic [RW-1:0] trial, rem_nx, res_nx;
	logic          broken, rail_break;
	logic [AW-1:0] nhead;
	logic [CW:0]   last_sum, tail_sum;

	assign in_rec = '{x: pos_x, y: pos_y, z: pos_z, space: space_id, kind: move_kind[0],
		facing: facing[1:0], rail: rail_id, link: link_id, epoch: epoch};
	assign gain   = Z_WEIGHT_BASE + {1'b0, side_gap_q};
	assign thr    = TILE_C * 32'(gain);
	assign bad_in = ({4'd0, side_gap_q} > MAXGAP_C) || (move_kind > 2'd1)
		|| (facing > 3'd3) || (epoch == 32'd0);

	// One step of the restoring square root.
	assign trial  = res_q + bit_q;
	assign rem_nx = (rem_q >= trial) ? (rem_q - trial) : rem_q;
	assign res_nx = (rem_q >= trial) ? ((res_q >> 1) + bit_q) : (res_q >> 1);
	assign root32 = 32'(res_nx[RTW-1:0]);

	assign path_add = path_q + root32;
	assign path_sub = path_q - root32;
	assign last_sum = (CW + 1)'(head_q) + (CW + 1)'(count_q) - (CW + 1)'(1);
	assign tail_sum = (CW + 1)'(head_q) + (CW + 1)'(count_q);
	assign nhead    = wrap((CW + 1)'(head_q) + (CW + 1)'(1));

	// Connection check against the newest stored sample.
	assign rail_break = (last_q.kind == KIND_RAIL) && (in_q.kind == KIND_RAIL)
		&& (last_q.rail != in_q.rail) && ((last_q.link == NO_LINK) || (last_q.link != in_q.link));
	assign broken = (last_q.epoch != in_q.epoch) || (last_q.space != in_q.space)
		|| (root32 > TILE_C) || dy_big_q || rail_break || (count_q >= DEPTH_C);

	assign op_a = (state_q == S_GOTB) ? a_q : in_q;

	// Sequencer next state and controls.
	always_comb begin
		nx_state = state_q;
		nx_phase = phase_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		waddr    = '0;
		raddr    = '0;
		wdata    = in_q;
		fin      = 1'b0;
		fin_stat = STAT_NONE;
		fin_rec  = a_q;
		do_clear = 1'b0;
		do_first = 1'b0;
		do_app   = 1'b0;
		do_add   = 1'b0;
		do_trim  = 1'b0;
		ld_a     = 1'b0;
		ld_b     = 1'b0;
		ld_d     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (cmd == CMD_CLEAR) begin
						do_clear = 1'b1;
						fin      = 1'b1;
					end else if (bad_in) begin
						do_clear = 1'b1;
						fin      = 1'b1;
						fin_stat = STAT_RESET;
					end else if (count_q == '0) begin
						mem_we   = 1'b1;
						wdata    = in_rec;
						do_first = 1'b1;
						fin      = 1'b1;
					end else begin
						mem_re   = 1'b1;
						raddr    = wrap(last_sum);
						nx_state = S_DELTA;
					end
				end
			end
			S_DELTA: begin
				ld_d     = 1'b1;
				nx_phase = PH_PLANAR;
				nx_state = S_MUL1;
			end
			S_MUL1: nx_state = S_MUL2;
			S_MUL2: nx_state = S_SUM;
			S_SUM:  nx_state = S_ROOT;
			S_ROOT: begin
				if (bit_q[0]) begin
					unique case (phase_q)
						PH_PLANAR: begin
							if (broken) begin
								do_clear = 1'b1;
								fin      = 1'b1;
								fin_stat = STAT_RESET;
								nx_state = S_IDLE;
							end else if (root32 == 32'd0 && last_q.y == in_q.y) begin
								fin      = 1'b1;
								nx_state = S_IDLE;
							end else begin
								mem_we   = 1'b1;
								waddr    = wrap(tail_sum);
								do_app   = 1'b1;
								nx_phase = PH_WEIGHT;
								nx_state = S_MUL1;
							end
						end
						PH_WEIGHT: begin
							do_add = 1'b1;
							if (path_add < thr) begin
								fin      = 1'b1;
								nx_state = S_IDLE;
							end else begin
								mem_re   = 1'b1;
								raddr    = head_q;
								nx_state = S_GOTA;
							end
						end
						PH_TRIM: begin
							if (path_sub < thr) begin
								fin      = 1'b1;
								fin_stat = STAT_EMIT;
								nx_state = S_IDLE;
							end else begin
								do_trim = 1'b1;
								if (count_q > CW'(2)) begin
									mem_re   = 1'b1;
									raddr    = wrap((CW + 1)'(nhead) + (CW + 1)'(1));
									nx_state = S_GOTB;
								end else begin
									fin      = 1'b1;
									fin_stat = STAT_EMIT;
									fin_rec  = b_q;
									nx_state = S_IDLE;
								end
							end
						end
						default: nx_state = S_IDLE;
					endcase
				end
			end
			S_GOTA: begin
				ld_a = 1'b1;
				if (count_q > CW'(1)) begin
					mem_re   = 1'b1;
					raddr    = nhead;
					nx_state = S_GOTB;
				end else begin
					fin      = 1'b1;
					fin_stat = STAT_EMIT;
					fin_rec  = rdata_q;
					nx_state = S_IDLE;
				end
			end
			S_GOTB: begin
				ld_b     = 1'b1;
				nx_phase = PH_TRIM;
				nx_state = S_MUL1;
			end
			default: nx_state = S_IDLE;
		endcase
	end

	// State and trail bookkeeping registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= PH_PLANAR;
			side_gap_q <= '0;
			head_q     <= '0;
			count_q    <= '0;
			path_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= nx_state;
			phase_q <= nx_phase;
			done_q  <= fin;
			if (cfg_valid && cfg_ready) begin
				side_gap_q <= cfg_data;
			end
			if (do_clear) begin
				head_q  <= '0;
				count_q <= '0;
				path_q  <= '0;
			end else if (do_first) begin
				head_q  <= '0;
				count_q <= CW'(1);
			end else if (do_app) begin
				count_q <= count_q + CW'(1);
			end else if (do_add) begin
				path_q <= path_add;
			end else if (do_trim) begin
				path_q  <= path_sub;
				head_q  <= nhead;
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Datapath registers: operands, products and the root unit.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			in_q <= in_rec;
		end
		if (ld_d) begin
			last_q   <= rdata_q;
			dy_big_q <= adelta(in_q.y, rdata_q.y) > Y_LIMIT;
		end
		if (ld_d || ld_b) begin
			dx_q <= adelta(op_a.x, rdata_q.x);
			dz_q <= adelta(op_a.z, rdata_q.z);
		end
		if (ld_a) begin
			a_q <= rdata_q;
		end
		if (ld_b) begin
			b_q <= rdata_q;
		end
		if (do_trim) begin
			a_q <= b_q;
		end
		if (state_q == S_MUL1) begin
			if (phase_q == PH_PLANAR) begin
				wx_q <= WXW'(dx_q);
				wz_q <= WXW'(dz_q);
			end else begin
				wx_q <= WXW'(dx_q) << X_WEIGHT_SHIFT;
				wz_q <= WXW'(dz_q) * WXW'(gain);
			end
		end
		if (state_q == S_MUL2) begin
			sqx_q <= wx_q * wx_q;
			sqz_q <= wz_q * wz_q;
		end
		if (state_q == S_SUM) begin
			rem_q <= RW'(sqx_q) + RW'(sqz_q);
			res_q <= '0;
			bit_q <= RW'(1) << (RW - 2);
		end else if (state_q == S_ROOT) begin
			rem_q <= rem_nx;
			res_q <= res_nx;
			bit_q <= bit_q >> 2;
		end
		if (fin) begin
			status_q <= fin_stat;
			out_q    <= (fin_stat == STAT_EMIT) ? fin_rec : '0;
		end
	end

	// Ring memory with a registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign cfg_ready  = 1'b1;
	assign done       = done_q;
	assign status     = status_q;
	assign out_x      = out_q.x;
	assign out_y      = out_q.y;
	assign out_z      = out_q.z;
	assign out_space  = out_q.space;
	assign out_kind   = out_q.kind;
	assign out_facing = out_q.facing;
	assign out_epoch  = out_q.epoch;
	assign out_rail   = out_q.rail;
	assign out_link   = out_q.link;

`ifndef SYNTHESIS
	// The fill never exceeds the ring depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C) else $error("ring fill above depth");

	// A result is only shown once the sequencer is back in idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");

	// An empty ring always carries a zero path length.
	a_empty_path: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (path_q == 32'd0)) else $error("path length on empty ring");

	// A request taken in idle either finishes next cycle or keeps the block busy.
	a_req_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy)) else $error("request lost");
`endif

endmodule
